### rtl/core/edge_darken_filter_unit_macros.svh
// Assertion helpers used by the checker file.
`ifndef EDGE_DARKEN_FILTER_UNIT_MACROS_SVH
`define EDGE_DARKEN_FILTER_UNIT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define EDF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define EDF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/edf_pkg.sv
package edf_pkg;

  localparam int PIX_W          = 8;
  localparam int LINE_W         = 3 * PIX_W;
  localparam int CFG_W_W        = 12;
  localparam int CFG_H_W        = 13;
  localparam int CFG_DATA_W     = 13;
  localparam int CFG_IDX_W      = 2;
  localparam int MAX_WIDTH_DEF  = 2048;
  localparam int MAX_HEIGHT_DEF = 4096;
  localparam int POW_STEPS      = 6;
  localparam int POW_CNT_W      = $clog2(POW_STEPS);
  localparam int DIV3_MUL       = 43691;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD0,
    ST_RD1,
    ST_SUM,
    ST_DIV3,
    ST_DIVN,
    ST_POW,
    ST_FIN
  } edf_state_t;

  typedef struct packed {
    logic accept;
    logic rd0;
    logic rd1;
    logic sum;
    logic div3;
    logic divn;
    logic pow;
    logic commit;
  } edf_cmd_t;

  typedef struct packed {
    logic emit_req;
    logic drop_req;
    logic commit_ok;
  } edf_status_t;

  // Sum of absolute channel differences between two packed pixels.
  function automatic logic [9:0] diff3(logic [LINE_W-1:0] a, logic [LINE_W-1:0] b);
    logic [PIX_W-1:0] x;
    logic [PIX_W-1:0] y;
    logic [9:0]       s;
    s = '0;
    for (int k = 0; k < 3; k++) begin
      x = a[PIX_W*k +: PIX_W];
      y = b[PIX_W*k +: PIX_W];
      s = s + 10'((x > y) ? (x - y) : (y - x));
    end
    return s;
  endfunction

  // Exact floor(x / 3) for 12-bit x by reciprocal multiplication.
  function automatic logic [11:0] div3(logic [11:0] x);
    logic [28:0] p;
    p = 29'(x) * 29'(DIV3_MUL);
    return p[28:17];
  endfunction

  // Exact floor(x / 255) for x up to 255 * 255.
  function automatic logic [PIX_W-1:0] div255(logic [15:0] x);
    logic [16:0] s;
    s = 17'(x) + 17'(x[15:8]) + 17'd1;
    return s[15:8];
  endfunction

endpackage

### rtl/core/edf_ram.sv
module edf_ram
  import edf_pkg::*;
#(
  parameter int WIDTH = LINE_W,
  parameter int DEPTH = MAX_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/core/edf_dp.sv
module edf_dp
  import edf_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  edf_cmd_t              cmd,
  output edf_status_t           st,
  input  logic                  in_mode,
  input  logic [PIX_W-1:0]      in_blue_in,
  input  logic [PIX_W-1:0]      in_green_in,
  input  logic [PIX_W-1:0]      in_red_in,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [PIX_W-1:0]      out_blue_out,
  output logic [PIX_W-1:0]      out_green_out,
  output logic [PIX_W-1:0]      out_red_out,
  output logic                  out_frame_end
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int HW = $clog2(MAX_HEIGHT + 1);

  // Frame geometry and position.
  logic [WW-1:0] eff_w_r;
  logic [HW-1:0] eff_h_r;
  logic [AW-1:0] col_r;
  logic [RW-1:0] row_r;
  logic          draining_r;

  // Item being worked on.
  logic              mode_r;
  logic              emit_r;
  logic [LINE_W-1:0] px_r;
  logic [LINE_W-1:0] ctr_r;
  logic [10:0]       part_r;
  logic [2:0]        n_r;
  logic [11:0]       sum_r;
  logic [11:0]       t_r;
  logic [PIX_W-1:0]  q_r;
  logic [PIX_W-1:0]  w_r;

  // Result register.
  logic             out_valid_r;
  logic [PIX_W-1:0] out_blue_r;
  logic [PIX_W-1:0] out_green_r;
  logic [PIX_W-1:0] out_red_r;
  logic             out_frame_end_r;

  logic [AW-1:0]     c_eff;
  logic [WW-1:0]     c_plus1;
  logic              last_col;
  logic [HW-1:0]     row_plus1;
  logic              row_last;
  logic              has_up;
  logic              has_left;
  logic              has_right;
  logic              has_down;
  logic [AW-1:0]     ctr_raddr;
  logic [AW-1:0]     abv_raddr;
  logic [LINE_W-1:0] ctr_rdata;
  logic [LINE_W-1:0] abv_rdata;
  logic              ctr_we;
  logic              abv_we;
  logic [LINE_W-1:0] in_px;
  logic [11:0]       d_val;
  logic [PIX_W-1:0]  q_val;
  logic [PIX_W-1:0]  edge_val;
  logic [CFG_W_W-1:0] cfg_w_val;
  logic [CFG_H_W-1:0] cfg_h_val;
  logic [WW-1:0]     cfg_w_eff;
  logic [HW-1:0]     cfg_h_eff;
  logic              cfg_hit;

  assign in_px = {in_red_in, in_green_in, in_blue_in};

  assign c_eff     = (WW'(col_r) >= eff_w_r) ? '0 : col_r;
  assign c_plus1   = WW'(c_eff) + WW'(1);
  assign last_col  = (c_plus1 >= eff_w_r);
  assign row_plus1 = HW'(row_r) + HW'(1);
  assign row_last  = (row_plus1 >= eff_h_r);

  // A flush item works on the last row, so its upper neighbour exists when
  // the frame has at least two rows.
  assign has_up    = mode_r ? (32'(eff_h_r) >= 32'd2) : (32'(row_r) >= 32'd2);
  assign has_left  = (c_eff != '0);
  assign has_right = !last_col;
  assign has_down  = !mode_r;

  assign st.drop_req  = in_mode ? !draining_r : draining_r;
  assign st.emit_req  = in_mode ? draining_r : (row_r != '0);
  assign st.commit_ok = !emit_r || !out_valid_r || out_ready;

  // The second read fetches the right neighbour from the center line and the
  // left neighbour from the above line, which already holds this row's pixels.
  assign ctr_raddr = cmd.rd1 ? c_plus1[AW-1:0] : c_eff;
  assign abv_raddr = cmd.rd1 ? (c_eff - AW'(1)) : c_eff;
  assign ctr_we    = cmd.commit && !mode_r;
  assign abv_we    = cmd.commit && emit_r;

  edf_ram #(
    .WIDTH (LINE_W),
    .DEPTH (MAX_WIDTH)
  ) u_ctr_ram (
    .clk   (clk),
    .we    (ctr_we),
    .waddr (c_eff),
    .wdata (px_r),
    .raddr (ctr_raddr),
    .rdata (ctr_rdata)
  );

  edf_ram #(
    .WIDTH (LINE_W),
    .DEPTH (MAX_WIDTH)
  ) u_abv_ram (
    .clk   (clk),
    .we    (abv_we),
    .waddr (c_eff),
    .wdata (ctr_r),
    .raddr (abv_raddr),
    .rdata (abv_rdata)
  );

  always_comb begin
    case (n_r)
      3'd1:    d_val = t_r;
      3'd2:    d_val = t_r >> 1;
      3'd3:    d_val = div3(t_r);
      3'd4:    d_val = t_r >> 2;
      default: d_val = '0;
    endcase
    // With no neighbours the curve must end at full scale, giving no edge.
    if (n_r == 3'd0) begin
      q_val = 8'd255;
    end else if (d_val > 12'd255) begin
      q_val = '0;
    end else begin
      q_val = 8'd255 - d_val[PIX_W-1:0];
    end
  end

  assign edge_val = 8'd255 - w_r;

  assign cfg_w_val = cfg_wdata[CFG_W_W-1:0];
  assign cfg_h_val = cfg_wdata[CFG_H_W-1:0];
  assign cfg_hit   = cfg_valid &&
                     ((cfg_index == REG_IMAGE_WIDTH) || (cfg_index == REG_IMAGE_HEIGHT));

  always_comb begin
    if (cfg_w_val == '0) begin
      cfg_w_eff = WW'(1);
    end else if (32'(cfg_w_val) > 32'(MAX_WIDTH)) begin
      cfg_w_eff = WW'(MAX_WIDTH);
    end else begin
      cfg_w_eff = WW'(cfg_w_val);
    end
    if (cfg_h_val == '0) begin
      cfg_h_eff = HW'(1);
    end else if (32'(cfg_h_val) > 32'(MAX_HEIGHT)) begin
      cfg_h_eff = HW'(MAX_HEIGHT);
    end else begin
      cfg_h_eff = HW'(cfg_h_val);
    end
  end

  // Control registers: geometry, counters and the result valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eff_w_r     <= WW'(1);
      eff_h_r     <= HW'(1);
      col_r       <= '0;
      row_r       <= '0;
      draining_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.commit && emit_r) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_hit) begin
        if (cfg_index == REG_IMAGE_WIDTH) begin
          eff_w_r <= cfg_w_eff;
        end else begin
          eff_h_r <= cfg_h_eff;
        end
        col_r      <= '0;
        row_r      <= '0;
        draining_r <= 1'b0;
      end else if (cmd.commit) begin
        if (!last_col) begin
          col_r <= c_plus1[AW-1:0];
        end else begin
          col_r <= '0;
          if (mode_r) begin
            row_r      <= '0;
            draining_r <= 1'b0;
          end else if (row_last) begin
            draining_r <= 1'b1;
          end else begin
            row_r <= row_plus1[RW-1:0];
          end
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mode_r <= in_mode;
      emit_r <= st.emit_req;
      px_r   <= in_px;
    end
    if (cmd.rd1) begin
      ctr_r  <= ctr_rdata;
      part_r <= 11'(has_up ? diff3(ctr_rdata, abv_rdata) : 10'd0) +
                11'(has_down ? diff3(ctr_rdata, px_r) : 10'd0);
      n_r    <= 3'(has_up) + 3'(has_down);
    end
    if (cmd.sum) begin
      sum_r <= 12'(part_r) +
               12'(has_left ? diff3(ctr_r, abv_rdata) : 10'd0) +
               12'(has_right ? diff3(ctr_r, ctr_rdata) : 10'd0);
      n_r   <= n_r + 3'(has_left) + 3'(has_right);
    end
    if (cmd.div3) begin
      t_r <= div3(sum_r);
    end
    if (cmd.divn) begin
      q_r <= q_val;
      w_r <= q_val;
    end
    if (cmd.pow) begin
      w_r <= div255(16'(w_r) * 16'(q_r));
    end
    if (cmd.commit && emit_r) begin
      out_blue_r      <= (ctr_r[7:0] > edge_val) ? (ctr_r[7:0] - edge_val) : '0;
      out_green_r     <= (ctr_r[15:8] > edge_val) ? (ctr_r[15:8] - edge_val) : '0;
      out_red_r       <= (ctr_r[23:16] > edge_val) ? (ctr_r[23:16] - edge_val) : '0;
      out_frame_end_r <= mode_r && last_col;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_blue_out  = out_blue_r;
  assign out_green_out = out_green_r;
  assign out_red_out   = out_red_r;
  assign out_frame_end = out_frame_end_r;

endmodule

### rtl/core/edf_ctrl.sv
module edf_ctrl
  import edf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  edf_status_t st,
  output edf_cmd_t    cmd
);

  edf_state_t           state_r;
  edf_state_t           state_nxt;
  logic [POW_CNT_W-1:0] cnt_r;
  logic [POW_CNT_W-1:0] cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          // Ignored items end here; first-row pixels only need storing.
          if (st.drop_req) begin
            state_nxt = ST_IDLE;
          end else if (st.emit_req) begin
            state_nxt = ST_RD0;
          end else begin
            state_nxt = ST_FIN;
          end
        end
      end
      ST_RD0: begin
        cmd.rd0   = 1'b1;
        state_nxt = ST_RD1;
      end
      ST_RD1: begin
        cmd.rd1   = 1'b1;
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        cmd.sum   = 1'b1;
        state_nxt = ST_DIV3;
      end
      ST_DIV3: begin
        cmd.div3  = 1'b1;
        state_nxt = ST_DIVN;
      end
      ST_DIVN: begin
        cmd.divn  = 1'b1;
        cnt_nxt   = '0;
        state_nxt = ST_POW;
      end
      ST_POW: begin
        cmd.pow = 1'b1;
        if (cnt_r == POW_CNT_W'(POW_STEPS - 1)) begin
          state_nxt = ST_FIN;
        end else begin
          cnt_nxt = cnt_r + POW_CNT_W'(1);
        end
      end
      ST_FIN: begin
        if (st.commit_ok) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

### rtl/core/edge_darken_filter_unit.sv
// Edge darkening filter for RGB frames in raster order.
// Input channel (in_*): one item per pixel with in_mode = 0, or a flush tick
// with in_mode = 1. The result for a pixel appears one row later; after the
// last pixel of a frame, image_width flush items drain the last row, and
// the last result carries out_frame_end.
// Configuration (cfg_*): index 0 is image_width, index 1 is image_height.
// A write to either register restarts the frame; write only while the block is idle.
// An item that yields a result passes through the line store reads, the
// sum, the divide by 3, the divide by the neighbour count and the six-step
// power curve on one shared 8x8 multiplier, then commits its result to the
// output register; only then is the next item accepted. A first-row pixel
// is only stored, and an ignored item is dropped when it is accepted.
// A finished result waits in the output register; if the receiver stalls,
// the next item may still be accepted and is held in its final step until
// the output register frees up.
// Reset: synchronous, active low; sizes return to 1x1 and the frame
// restarts. Line store contents are not cleared.
module edge_darken_filter_unit
  import edf_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_mode,
  input  logic [PIX_W-1:0]      in_blue_in,
  input  logic [PIX_W-1:0]      in_green_in,
  input  logic [PIX_W-1:0]      in_red_in,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [PIX_W-1:0]      out_blue_out,
  output logic [PIX_W-1:0]      out_green_out,
  output logic [PIX_W-1:0]      out_red_out,
  output logic                  out_frame_end,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  edf_cmd_t    cmd;
  edf_status_t st;

  assign cfg_ready = 1'b1;

  edf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  edf_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .st            (st),
    .in_mode       (in_mode),
    .in_blue_in    (in_blue_in),
    .in_green_in   (in_green_in),
    .in_red_in     (in_red_in),
    .cfg_valid     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_blue_out  (out_blue_out),
    .out_green_out (out_green_out),
    .out_red_out   (out_red_out),
    .out_frame_end (out_frame_end)
  );

endmodule

### rtl/core/edf_checker.sv
`include "edge_darken_filter_unit_macros.svh"

module edf_checker
  import edf_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [PIX_W-1:0] out_blue_out,
  input logic [PIX_W-1:0] out_green_out,
  input logic [PIX_W-1:0] out_red_out,
  input logic             out_frame_end
);

  // A stalled result keeps its payload.
  `EDF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(out_blue_out) && $stable(out_green_out) &&
    $stable(out_red_out) && $stable(out_frame_end), "result changed while stalled")

  // A new result is loaded only in a cycle in which no item is taken.
  `EDF_ASSERT_NOW(a_out_busy, $rose(out_valid), !$past(in_ready),
    "result appeared straight after an idle cycle")

  // Nothing is offered right after reset.
  `EDF_ASSERT_NOW(a_reset_empty, $past(!rst_n), !out_valid && in_ready,
    "block not empty after reset")

endmodule

bind edge_darken_filter_unit edf_checker u_edf_checker (.*);

### bench/tb_edge_darken_filter_unit.sv
`timescale 1ns / 1ps

module tb_edge_darken_filter_unit;
  import edf_pkg::*;

  localparam int CYCLE_LIMIT   = 1000000;
  localparam int RAND_ITEMS    = 2000;
  localparam int SETTLE_CYCLES = 16;
  localparam int TAIL_CYCLES   = 40;

  localparam logic MODE_PIXEL = 1'b0;
  localparam logic MODE_FLUSH = 1'b1;

  // Indexes that map to no register.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_B = 2'd3;

  typedef struct packed {
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] red;
    logic             frame_end;
  } pix_result_t;

  localparam pix_result_t NO_RES = '0;

  typedef enum logic [1:0] {ROW_DATA, ROW_FLUSH, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    logic [PIX_W-1:0]      blue;
    logic [PIX_W-1:0]      green;
    logic [PIX_W-1:0]      red;
    logic                  typed;
    pix_result_t           res;
  } stim_row_t;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  in_mode = 1'b0;
  logic [PIX_W-1:0]      in_blue_in = '0;
  logic [PIX_W-1:0]      in_green_in = '0;
  logic [PIX_W-1:0]      in_red_in = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [PIX_W-1:0]      out_blue_out;
  logic [PIX_W-1:0]      out_green_out;
  logic [PIX_W-1:0]      out_red_out;
  logic                  out_frame_end;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  edge_darken_filter_unit uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_mode       (in_mode),
    .in_blue_in    (in_blue_in),
    .in_green_in   (in_green_in),
    .in_red_in     (in_red_in),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_blue_out  (out_blue_out),
    .out_green_out (out_green_out),
    .out_red_out   (out_red_out),
    .out_frame_end (out_frame_end),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Filter state as the block should hold it.
  logic [CFG_W_W-1:0] img_w_reg = 12'd1;
  logic [CFG_H_W-1:0] img_h_reg = 13'd1;
  int unsigned        cur_row = 0;
  int unsigned        cur_col = 0;
  bit                 draining = 1'b0;
  logic [LINE_W-1:0]  line_two_up [MAX_WIDTH_DEF];
  logic [LINE_W-1:0]  line_one_up [MAX_WIDTH_DEF];

  pix_result_t pending_pix [$];
  pix_result_t got_pix;
  pix_result_t want_pix;
  int          fails = 0;
  int          cycle_cnt = 0;
  bit          calm = 1'b0;
  stim_row_t   dir_rows [25];

  function automatic int unsigned width_used();
    if (img_w_reg == 0) return 1;
    if (img_w_reg > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
    return img_w_reg;
  endfunction

  function automatic int unsigned height_used();
    if (img_h_reg == 0) return 1;
    if (img_h_reg > MAX_HEIGHT_DEF) return MAX_HEIGHT_DEF;
    return img_h_reg;
  endfunction

  function automatic int unsigned color_dist(logic [LINE_W-1:0] a, logic [LINE_W-1:0] b);
    int unsigned s;
    s = 0;
    for (int k = 0; k < 3; k++) begin
      if (a[8*k +: 8] > b[8*k +: 8]) s += a[8*k +: 8] - b[8*k +: 8];
      else s += b[8*k +: 8] - a[8*k +: 8];
    end
    return s;
  endfunction

  // Darkened version of the stored pixel at column c of the row above the
  // incoming one, with the neighbours that exist.
  function automatic pix_result_t darken_at(int unsigned c, int unsigned w, bit has_up,
                                            bit has_down, logic [LINE_W-1:0] down,
                                            bit last);
    logic [LINE_W-1:0] ctr;
    int unsigned       sum, n, d, q, lvl, strength;
    pix_result_t       r;
    ctr = line_one_up[c];
    sum = 0;
    n = 0;
    if (has_up) begin
      sum += color_dist(ctr, line_two_up[c]);
      n++;
    end
    if (c > 0) begin
      sum += color_dist(ctr, line_two_up[c-1]);
      n++;
    end
    if (has_down) begin
      sum += color_dist(ctr, down);
      n++;
    end
    if (c + 1 < w) begin
      sum += color_dist(ctr, line_one_up[c+1]);
      n++;
    end
    strength = 0;
    if (n != 0) begin
      d = sum / 3 / n;
      q = (d > 255) ? 0 : 255 - d;
      lvl = q;
      repeat (6) lvl = lvl * q / 255;
      strength = 255 - lvl;
    end
    r.blue      = (ctr[7:0] > strength) ? 8'(ctr[7:0] - strength) : 8'd0;
    r.green     = (ctr[15:8] > strength) ? 8'(ctr[15:8] - strength) : 8'd0;
    r.red       = (ctr[23:16] > strength) ? 8'(ctr[23:16] - strength) : 8'd0;
    r.frame_end = last;
    return r;
  endfunction

  // Advances the filter state by one item; returns 1 when it yields a result.
  function automatic bit predict_item(input logic mode, input logic [LINE_W-1:0] px,
                                      output pix_result_t res);
    int unsigned w, h, c;
    bit          made, last;
    w = width_used();
    h = height_used();
    c = (cur_col >= w) ? 0 : cur_col;
    res = NO_RES;
    made = 1'b0;
    if (mode == MODE_PIXEL) begin
      if (draining) return 1'b0;
      if (cur_row >= 1) begin
        res = darken_at(c, w, cur_row >= 2, 1'b1, px, 1'b0);
        line_two_up[c] = line_one_up[c];
        made = 1'b1;
      end
      line_one_up[c] = px;
      c++;
      if (c >= w) begin
        c = 0;
        if (cur_row + 1 >= h) draining = 1'b1;
        else cur_row++;
      end
      cur_col = c;
    end else begin
      if (!draining) return 1'b0;
      last = (c + 1 >= w);
      res = darken_at(c, w, h >= 2, 1'b0, '0, last);
      line_two_up[c] = line_one_up[c];
      if (last) begin
        cur_col = 0;
        cur_row = 0;
        draining = 1'b0;
      end else begin
        cur_col = c + 1;
      end
      made = 1'b1;
    end
    return made;
  endfunction

  function automatic logic [LINE_W-1:0] rand_px(logic [LINE_W-1:0] base, int unsigned amp);
    logic [LINE_W-1:0] px;
    int                v;
    for (int k = 0; k < 3; k++) begin
      v = int'(base[8*k +: 8]) + int'($urandom_range(2 * amp)) - int'(amp);
      if (v < 0) v = 0;
      else if (v > 255) v = 255;
      px[8*k +: 8] = 8'(v);
    end
    return px;
  endfunction

  task automatic send_item(input logic mode, input logic [LINE_W-1:0] px, input bit typed,
                           input pix_result_t typed_res);
    pix_result_t res;
    while (!calm && $urandom_range(99) < 19) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_mode     <= mode;
    in_blue_in  <= px[7:0];
    in_green_in <= px[15:8];
    in_red_in   <= px[23:16];
    do @(posedge clk); while (!in_ready);
    if (predict_item(mode, px, res)) pending_pix.push_back(typed ? typed_res : res);
  endtask

  // Always waits on the clock before it returns, so that the next drive lands in a later step.
  task automatic wait_results_done();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_pix.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    wait_results_done();
    // Items that yield nothing may still be in flight.
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_IMAGE_WIDTH: begin
        img_w_reg = val[CFG_W_W-1:0];
        cur_row = 0;
        cur_col = 0;
        draining = 1'b0;
      end
      REG_IMAGE_HEIGHT: begin
        img_h_reg = val[CFG_H_W-1:0];
        cur_row = 0;
        cur_col = 0;
        draining = 1'b0;
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) out_ready <= calm || ($urandom_range(99) >= 19);

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      got_pix = {out_blue_out, out_green_out, out_red_out, out_frame_end};
      if (pending_pix.size() == 0) begin
        $display("%0t: unexpected result b=%0d g=%0d r=%0d end=%0d", $time,
                 got_pix.blue, got_pix.green, got_pix.red, got_pix.frame_end);
        fails++;
      end else begin
        want_pix = pending_pix.pop_front();
        if (got_pix !== want_pix) begin
          $display("%0t: mismatch expected b=%0d g=%0d r=%0d end=%0d, got b=%0d g=%0d r=%0d end=%0d",
                   $time, want_pix.blue, want_pix.green, want_pix.red, want_pix.frame_end,
                   got_pix.blue, got_pix.green, got_pix.red, got_pix.frame_end);
          fails++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("FAIL edge_darken_filter_unit");
      $finish;
    end
  end

  initial begin
    int unsigned       done_items, fw, fh, w, h, amp, npix;
    logic [LINE_W-1:0] base;
    bit                must_cfg;
    done_items = 0;

    // Size is 1x1 out of reset, so a frame is one pixel and one flush.
    dir_rows = '{
      '{ROW_DATA,  '0, '0, 8'h12, 8'h34, 8'h56, 1'b0, NO_RES},
      '{ROW_FLUSH, '0, '0, 8'h00, 8'h00, 8'h00, 1'b1, '{8'h12, 8'h34, 8'h56, 1'b1}},
      '{ROW_FLUSH, '0, '0, 8'hff, 8'hff, 8'hff, 1'b0, NO_RES},
      '{ROW_DATA,  '0, '0, 8'h00, 8'h00, 8'h00, 1'b0, NO_RES},
      '{ROW_DATA,  '0, '0, 8'h09, 8'h09, 8'h09, 1'b0, NO_RES},
      '{ROW_FLUSH, '0, '0, 8'h00, 8'h00, 8'h00, 1'b1, '{8'h00, 8'h00, 8'h00, 1'b1}},
      '{ROW_CFG, REG_UNUSED_A, 13'h0aaa, 8'h00, 8'h00, 8'h00, 1'b0, NO_RES},
      '{ROW_CFG, REG_IMAGE_WIDTH, 13'd2, 8'h00, 8'h00, 8'h00, 1'b0, NO_RES},
      '{ROW_CFG, REG_IMAGE_HEIGHT, 13'd0, 8'h00, 8'h00, 8'h00, 1'b0, NO_RES},
      '{ROW_DATA,  '0, '0, 8'h00, 8'h00, 8'h00, 1'b0, NO_RES},
      '{ROW_DATA,  '0, '0, 8'hff, 8'hff, 8'hff, 1'b0, NO_RES},
      '{ROW_FLUSH, '0, '0, 8'h00, 8'h00, 8'h00, 1'b1, '{8'h00, 8'h00, 8'h00, 1'b0}},
      '{ROW_FLUSH, '0, '0, 8'h00, 8'h00, 8'h00, 1'b1, '{8'h00, 8'h00, 8'h00, 1'b1}},
      '{ROW_CFG, REG_IMAGE_WIDTH, 13'h1000, 8'h00, 8'h00, 8'h00, 1'b0, NO_RES},
      '{ROW_CFG, REG_IMAGE_HEIGHT, 13'd2, 8'h00, 8'h00, 8'h00, 1'b0, NO_RES},
      '{ROW_DATA,  '0, '0, 8'hc8, 8'h64, 8'h32, 1'b0, NO_RES},
      '{ROW_DATA,  '0, '0, 8'hc8, 8'h64, 8'h32, 1'b1, '{8'hc8, 8'h64, 8'h32, 1'b0}},
      '{ROW_FLUSH, '0, '0, 8'h00, 8'h00, 8'h00, 1'b1, '{8'hc8, 8'h64, 8'h32, 1'b1}},
      '{ROW_CFG, REG_IMAGE_WIDTH, 13'd2, 8'h00, 8'h00, 8'h00, 1'b0, NO_RES},
      '{ROW_DATA,  '0, '0, 8'h10, 8'h20, 8'h30, 1'b0, NO_RES},
      '{ROW_DATA,  '0, '0, 8'hf0, 8'he0, 8'hd0, 1'b0, NO_RES},
      '{ROW_DATA,  '0, '0, 8'h00, 8'hff, 8'h80, 1'b0, NO_RES},
      '{ROW_DATA,  '0, '0, 8'h7f, 8'h01, 8'hfe, 1'b0, NO_RES},
      '{ROW_FLUSH, '0, '0, 8'h00, 8'h00, 8'h00, 1'b0, NO_RES},
      '{ROW_FLUSH, '0, '0, 8'h00, 8'h00, 8'h00, 1'b0, NO_RES}
    };

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      case (dir_rows[i].kind)
        ROW_CFG:  write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
        ROW_DATA: send_item(MODE_PIXEL, {dir_rows[i].red, dir_rows[i].green, dir_rows[i].blue},
                            dir_rows[i].typed, dir_rows[i].res);
        default:  send_item(MODE_FLUSH, {dir_rows[i].red, dir_rows[i].green, dir_rows[i].blue},
                            dir_rows[i].typed, dir_rows[i].res);
      endcase
    end

    // Oversized width is clamped: the second row only starts after the
    // widest row the line stores hold.
    write_reg(REG_IMAGE_WIDTH, 13'h0fff);
    write_reg(REG_IMAGE_HEIGHT, 13'd2);
    base = 24'($urandom);
    for (int i = 0; i < MAX_WIDTH_DEF + 16; i++)
      send_item(MODE_PIXEL, rand_px(base, 24), 1'b0, NO_RES);
    write_reg(REG_IMAGE_HEIGHT, 13'h1fff);
    write_reg(REG_IMAGE_WIDTH, 13'd3);
    for (int i = 0; i < 15; i++)
      send_item(MODE_PIXEL, rand_px(base, 255), 1'b0, NO_RES);

    // Whole frames with random content, with stray flushes, stray pixels
    // during the drain and the odd frame cut short.
    must_cfg = 1'b1;
    while (done_items < RAND_ITEMS) begin
      calm = (done_items >= 600 && done_items < 900);
      if (must_cfg || $urandom_range(3) != 0) begin
        case ($urandom_range(9))
          0:       fw = 0;
          1:       fw = 1;
          default: fw = $urandom_range(2, 8);
        endcase
        case ($urandom_range(9))
          0:       fh = 0;
          1:       fh = 1;
          default: fh = $urandom_range(2, 6);
        endcase
        write_reg(REG_IMAGE_WIDTH, {1'($urandom_range(1)), 12'(fw)});
        write_reg(REG_IMAGE_HEIGHT, 13'(fh));
        if ($urandom_range(7) == 0)
          write_reg($urandom_range(1) ? REG_UNUSED_A : REG_UNUSED_B, 13'($urandom));
        must_cfg = 1'b0;
      end
      w = width_used();
      h = height_used();
      npix = w * h;
      if ($urandom_range(9) == 0) begin
        npix = $urandom_range(w * h - 1);
        must_cfg = 1'b1;
      end
      base = 24'($urandom);
      case ($urandom_range(4))
        0:       amp = 0;
        1:       amp = 3;
        2:       amp = 12;
        3:       amp = 50;
        default: amp = 255;
      endcase
      for (int i = 0; i < npix; i++) begin
        if ($urandom_range(24) == 0) send_item(MODE_FLUSH, 24'($urandom), 1'b0, NO_RES);
        if ($urandom_range(99) == 0) wait_results_done();
        send_item(MODE_PIXEL, rand_px(base, amp), 1'b0, NO_RES);
        done_items++;
      end
      if (!must_cfg) begin
        for (int j = 0; j < w; j++) begin
          if ($urandom_range(24) == 0) send_item(MODE_PIXEL, 24'($urandom), 1'b0, NO_RES);
          send_item(MODE_FLUSH, 24'($urandom), 1'b0, NO_RES);
          done_items++;
        end
      end
    end
    calm = 1'b0;

    wait_results_done();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fails == 0) begin
      $display("PASS edge_darken_filter_unit");
    end else begin
      $display("FAIL edge_darken_filter_unit");
    end
    $finish;
  end

endmodule

### edge_darken_filter_unit.f
+incdir+rtl/core
rtl/core/edf_pkg.sv
rtl/core/edf_ram.sv
rtl/core/edf_dp.sv
rtl/core/edf_ctrl.sv
rtl/core/edge_darken_filter_unit.sv
rtl/core/edf_checker.sv
bench/tb_edge_darken_filter_unit.sv
